// File: src/tmcbs_pkg.sv
// Package with format codes and the format decoder for the mip chain size block.
package tmcbs_pkg;

  localparam int DimW   = 16;
  localparam int CountW = 5;
  localparam int FmtW   = 4;
  localparam int SumW   = 32;
  localparam int ShiftW = 3;

  // Pixel format codes.
  localparam logic [FmtW-1:0] FMT_DXT1     = 4'd0;
  localparam logic [FmtW-1:0] FMT_DXT2     = 4'd1;
  localparam logic [FmtW-1:0] FMT_DXT3     = 4'd2;
  localparam logic [FmtW-1:0] FMT_DXT4     = 4'd3;
  localparam logic [FmtW-1:0] FMT_DXT5     = 4'd4;
  localparam logic [FmtW-1:0] FMT_A8R8G8B8 = 4'd5;
  localparam logic [FmtW-1:0] FMT_X8R8G8B8 = 4'd6;
  localparam logic [FmtW-1:0] FMT_R5G6B5   = 4'd7;
  localparam logic [FmtW-1:0] FMT_X1R5G5B5 = 4'd8;
  localparam logic [FmtW-1:0] FMT_A1R5G5B5 = 4'd9;
  localparam logic [FmtW-1:0] FMT_A4R4G4B4 = 4'd10;
  localparam logic [FmtW-1:0] FMT_A8L8     = 4'd11;
  localparam logic [FmtW-1:0] FMT_A8       = 4'd12;

  // Decoded format: supported, block compressed, log2 of bytes per unit.
  typedef struct packed {
    logic              supported;
    logic              block;
    logic [ShiftW-1:0] shift;
  } fmt_info_t;

  function automatic fmt_info_t decode_fmt(input logic [FmtW-1:0] fmt);
    fmt_info_t info;
    info = '0;
    case (fmt) inside
      FMT_DXT1: begin
        info = '{supported: 1'b1, block: 1'b1, shift: 3'd3};
      end
      FMT_DXT2, FMT_DXT3, FMT_DXT4, FMT_DXT5: begin
        info = '{supported: 1'b1, block: 1'b1, shift: 3'd4};
      end
      FMT_A8R8G8B8, FMT_X8R8G8B8: begin
        info = '{supported: 1'b1, block: 1'b0, shift: 3'd2};
      end
      FMT_R5G6B5, FMT_X1R5G5B5, FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_A8L8: begin
        info = '{supported: 1'b1, block: 1'b0, shift: 3'd1};
      end
      FMT_A8: begin
        info = '{supported: 1'b1, block: 1'b0, shift: 3'd0};
      end
      default: begin
        info = '0;
      end
    endcase
    return info;
  endfunction

endpackage

// File: src/tmcbs_if.sv
// Request and response channel interfaces for the mip chain size block.
interface tmcbs_req_if
  import tmcbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DimW-1:0]   tex_width;
  logic [DimW-1:0]   tex_height;
  logic [DimW-1:0]   tex_depth;
  logic [CountW-1:0] level_count;
  logic [FmtW-1:0]   pixel_format;

  modport source (
    output valid, tex_width, tex_height, tex_depth, level_count, pixel_format,
    input  ready
  );
  modport sink (
    input  valid, tex_width, tex_height, tex_depth, level_count, pixel_format,
    output ready
  );
endinterface

interface tmcbs_rsp_if
  import tmcbs_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [SumW-1:0] total_bytes;
  logic            format_error;

  modport source (output valid, total_bytes, format_error, input ready);
  modport sink   (input valid, total_bytes, format_error, output ready);
endinterface

// File: src/tmcbs_mul.sv
// Shared registered multiplier: 32 by 16 bits, low 32 bits of the product kept.
module tmcbs_mul
  import tmcbs_pkg::*;
(
  input  logic            clk,
  input  logic [SumW-1:0] a,
  input  logic [DimW-1:0] b,
  output logic [SumW-1:0] p
);

  logic [SumW+DimW-1:0] full;

  // Products wrap modulo 2^32, so only the low word is registered.
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[SumW-1:0];
  end

endmodule

// File: src/texture_mip_chain_byte_size.sv
// Top level: sequencer that sums the byte sizes of a texture's mip levels.
//
// One request item on req (width, height, depth, level count, pixel format)
// yields one response item on rsp (total byte size modulo 2^32, error flag).
// Both channels use a valid/ready handshake; an item moves when both are high.
// Each level uses one shared 32x16 multiplier, in S_MUL_WH and then S_MUL_D:
// first the width times the height (in pixels or in 4x4 blocks), then that
// product, scaled by the bytes per unit, times the depth. The add into the
// running sum overlaps the next level's first multiply. An unsupported format
// or a zero level count goes from idle straight to the finish step. The block
// is not ready while an item is in work.
// The response is held in an output register; the next request is accepted
// while a finished response still waits for the receiver. If the receiver
// stalls, a second finished item waits in the last step until the output
// register frees up. Synchronous reset returns the sequencer to idle and drops
// any pending response.
module texture_mip_chain_byte_size
  import tmcbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tmcbs_req_if.sink   req,
  tmcbs_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL_WH,
    S_MUL_D,
    S_FINISH
  } state_t;

  state_t            state;
  logic [DimW-1:0]   w;
  logic [DimW-1:0]   h;
  logic [DimW-1:0]   d;
  logic [CountW-1:0] remaining;
  fmt_info_t         info;
  logic [SumW-1:0]   sum;
  logic              add_pending;
  logic              err;
  logic              rsp_valid;

  fmt_info_t         req_info;
  logic [DimW:0]     w_round;
  logic [DimW:0]     h_round;
  logic [DimW-1:0]   w_eff;
  logic [DimW-1:0]   h_eff;
  logic [SumW-1:0]   scaled;
  logic [SumW-1:0]   mul_a;
  logic [DimW-1:0]   mul_b;
  logic [SumW-1:0]   mul_p;
  logic [SumW-1:0]   sum_next;

  assign req_info  = decode_fmt(req.pixel_format);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;

  // Block formats count 4x4 blocks, rounded up.
  assign w_round = {1'b0, w} + (DimW+1)'(3);
  assign h_round = {1'b0, h} + (DimW+1)'(3);
  assign w_eff   = info.block ? DimW'(w_round >> 2) : w;
  assign h_eff   = info.block ? DimW'(h_round >> 2) : h;

  // Pixel or block count times bytes per unit, wrapping at 32 bits.
  assign scaled = mul_p << info.shift;

  // Operand selection for the shared multiplier.
  always_comb begin
    if (state == S_MUL_D) begin
      mul_a = scaled;
      mul_b = d;
    end else begin
      mul_a = {{(SumW-DimW){1'b0}}, w_eff};
      mul_b = h_eff;
    end
  end

  // The previous level's depth product is added from the multiplier output in the step that follows its multiply.
  assign sum_next = add_pending ? sum + mul_p : sum;

  tmcbs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      add_pending <= 1'b0;
    end else begin
      // The finish step reloads the output register itself when it frees up.
      if (rsp_valid && rsp.ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          add_pending <= 1'b0;
          if (req.valid) begin
            w         <= req.tex_width;
            h         <= req.tex_height;
            d         <= req.tex_depth;
            remaining <= req.level_count;
            info      <= req_info;
            sum       <= '0;
            err       <= !req_info.supported && (req.level_count != '0);
            if (req_info.supported && (req.level_count != '0)) begin
              state <= S_MUL_WH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_MUL_WH: begin
          sum         <= sum_next;
          add_pending <= 1'b0;
          if (w > DimW'(1)) w <= w >> 1;
          if (h > DimW'(1)) h <= h >> 1;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          add_pending <= 1'b1;
          if (d > DimW'(1)) d <= d >> 1;
          remaining <= remaining - CountW'(1);
          if (remaining == CountW'(1)) begin
            state <= S_FINISH;
          end else begin
            state <= S_MUL_WH;
          end
        end
        S_FINISH: begin
          sum         <= sum_next;
          add_pending <= 1'b0;
          if (!rsp_valid || rsp.ready) begin
            rsp.total_bytes  <= sum_next;
            rsp.format_error <= err;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the mip chain byte size block with random handshake stalls.
`timescale 1ns / 100ps

module testbench;
  import tmcbs_pkg::*;

  // Format code outside the supported set, used for the zero-level unsupported case.
  localparam logic [FmtW-1:0] FMT_UNSUPPORTED = 4'd15;
  // Idle time after the last result, so any item still in flight can finish.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1000;
  // Number of items at the end of the run that are sent without any idling.
  localparam int QUIET_TAIL   = 150;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [DimW-1:0]   depth;
    logic [CountW-1:0] levels;
    logic [FmtW-1:0]   fmt;
    bit                drain_first;
  } texture_request_t;

  typedef struct {
    logic [SumW-1:0] total_bytes;
    logic            format_error;
  } chain_size_t;

  logic clk;
  logic rst;

  tmcbs_req_if req ();
  tmcbs_rsp_if rsp ();

  texture_mip_chain_byte_size dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  texture_request_t pending_requests[$];
  chain_size_t      expected_sizes[$];
  texture_request_t cur_request;
  chain_size_t      want_size;
  int               items_accepted = 0;
  int               results_seen = 0;
  int               total_items = 0;
  int               failures = 0;
  int               send_gap = 0;
  int               stall_left = 0;
  bit               req_fire;

  // Computes the byte footprint of a whole mip chain, wrapping at 32 bits.
  function automatic chain_size_t mip_chain_size(texture_request_t r);
    chain_size_t res;
    logic [63:0] w, h, d, unit, lvl, sum;
    bit          blocked;
    res = '{total_bytes: '0, format_error: 1'b0};
    blocked = 1'b0;
    case (r.fmt)
      FMT_DXT1: begin
        unit = 8;
        blocked = 1'b1;
      end
      FMT_DXT2, FMT_DXT3, FMT_DXT4, FMT_DXT5: begin
        unit = 16;
        blocked = 1'b1;
      end
      FMT_A8R8G8B8, FMT_X8R8G8B8: begin
        unit = 4;
      end
      FMT_R5G6B5, FMT_X1R5G5B5, FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_A8L8: begin
        unit = 2;
      end
      FMT_A8: begin
        unit = 1;
      end
      default: begin
        unit = 0;
      end
    endcase
    if (unit == 0) begin
      res.format_error = (r.levels != 0);
      return res;
    end
    w = 64'(r.width);
    h = 64'(r.height);
    d = 64'(r.depth);
    sum = 0;
    for (int i = 0; i < r.levels; i++) begin
      if (blocked) begin
        lvl = (unit * ((w + 3) >> 2) * ((h + 3) >> 2)) & MASK32;
      end else begin
        lvl = (unit * w * h) & MASK32;
      end
      sum = (sum + ((d * lvl) & MASK32)) & MASK32;
      if (w > 1) w = w >> 1;
      if (h > 1) h = h >> 1;
      if (d > 1) d = d >> 1;
    end
    res.total_bytes = sum[SumW-1:0];
    return res;
  endfunction

  task automatic add_request(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                             input logic [DimW-1:0] d, input logic [CountW-1:0] n,
                             input logic [FmtW-1:0] f, input bit drain = 1'b0);
    texture_request_t r;
    r = '{width: w, height: h, depth: d, levels: n, fmt: f, drain_first: drain};
    pending_requests.push_back(r);
  endtask

  // Mixes full-range values with small sizes and powers of two.
  function automatic logic [DimW-1:0] random_dim();
    case ($urandom_range(0, 3))
      0: return DimW'($urandom);
      1: return 16'd1 << $urandom_range(0, 15);
      2: return DimW'($urandom_range(0, 64));
      default: return DimW'($urandom_range(1, 2048));
    endcase
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver: records each accepted item and presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      req_fire = req.valid && req.ready;
      if (req_fire) begin
        expected_sizes.push_back(mip_chain_size(cur_request));
        items_accepted <= items_accepted + 1;
      end
      if (req.valid && !req_fire) begin
        // Hold the current item until the block takes it.
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        req.valid <= 1'b0;
      end else if (pending_requests[0].drain_first &&
                   (req_fire || items_accepted != results_seen)) begin
        req.valid <= 1'b0;
      end else if (pending_requests.size() > QUIET_TAIL &&
                   (pending_requests.size() / 64) % 3 != 0 &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 6) - 1;
        req.valid <= 1'b0;
      end else begin
        cur_request = pending_requests.pop_front();
        req.valid        <= 1'b1;
        req.tex_width    <= cur_request.width;
        req.tex_height   <= cur_request.height;
        req.tex_depth    <= cur_request.depth;
        req.level_count  <= cur_request.levels;
        req.pixel_format <= cur_request.fmt;
      end
    end
  end

  // Response monitor: checks each result item and stalls the block at random.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen <= results_seen + 1;
        if (expected_sizes.size() == 0) begin
          $error("unexpected result item: total_bytes %0d format_error %0b",
                 rsp.total_bytes, rsp.format_error);
          failures++;
        end else begin
          want_size = expected_sizes.pop_front();
          if (rsp.total_bytes !== want_size.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d",
                   want_size.total_bytes, rsp.total_bytes);
            failures++;
          end
          if (rsp.format_error !== want_size.format_error) begin
            $error("format_error: expected %0b, got %0b",
                   want_size.format_error, rsp.format_error);
            failures++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (results_seen < total_items - QUIET_TAIL &&
                   (results_seen / 50) % 3 != 0 &&
                   $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    texture_request_t r;
    rst = 1'b1;
    req.valid = 1'b0;
    req.tex_width = '0;
    req.tex_height = '0;
    req.tex_depth = '0;
    req.level_count = '0;
    req.pixel_format = '0;
    rsp.ready = 1'b0;

    // Every format code, supported or not, on a small chain.
    for (int f = 0; f < 16; f++) begin
      add_request(16'd37, 16'd19, 16'd1, 5'd6, f[FmtW-1:0]);
    end
    // Largest sizes, so the first levels' products and the running sum wrap.
    add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, FMT_DXT5);
    add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, FMT_A8R8G8B8);
    // No levels, with a supported and with an unsupported format.
    add_request(16'd64, 16'd64, 16'd1, 5'd0, FMT_DXT1);
    add_request(16'd64, 16'd64, 16'd1, 5'd0, FMT_UNSUPPORTED);
    // Zero width, zero height and zero depth add nothing at any level.
    add_request(16'd0, 16'd128, 16'd4, 5'd8, FMT_R5G6B5);
    add_request(16'd128, 16'd0, 16'd4, 5'd8, FMT_DXT3);
    add_request(16'd256, 16'd256, 16'd0, 5'd9, FMT_A8);
    // Dimensions already at one stay there, and partial blocks round up.
    add_request(16'd1, 16'd1, 16'd1, 5'd31, FMT_DXT1);
    add_request(16'd5, 16'd3, 16'd32, 5'd10, FMT_DXT1, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r.width = random_dim();
      r.height = random_dim();
      r.depth = ($urandom_range(0, 2) == 0) ? 16'd1 : random_dim();
      r.levels = CountW'($urandom_range(0, 31));
      r.fmt = ($urandom_range(0, 9) == 0) ? FmtW'($urandom_range(13, 15))
                                          : FmtW'($urandom_range(0, 12));
      r.drain_first = (i == 300 || i == 700);
      pending_requests.push_back(r);
    end
    total_items = pending_requests.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted != total_items || expected_sizes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
